// ===== rtl/core/binary_row_run_table_macros.svh =====
// Assertion macros used by the run table checker.
`ifndef BINARY_ROW_RUN_TABLE_MACROS_SVH
`define BINARY_ROW_RUN_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BRRT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BRRT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brrt_pkg.sv =====
// Command and register codes of the binary row run table.
package brrt_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e_t;

  localparam logic [1:0] REG_DATA_COLOR   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

endpackage

// ===== rtl/core/brrt_ram.sv =====
// Simple dual-port synchronous RAM with registered read.
module brrt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/binary_row_run_table.sv =====
// Top level of the binary row run table: sequencer, run memory and count memory.
//
//   channel   direction  handshake                 payload
//   command   in         start & !busy             command pixel column row run_index
//   config    in         cfg_valid & cfg_ready     cfg_index cfg_data
//   result    out        done (one-cycle strobe)   status out_row out_index run_start
//                                                  run_length is_data
//
// A load reads the row count at its transfer, then writes the update in S_LOAD.
// A run read checks the count and reads one run in S_RDCNT, reported from S_RDDAT; out of
// range it ends in S_RDCNT. A query reads the row count in S_QCNT and ends there outside
// the image or on an empty row; else S_QSCAN examines one run per cycle, at most MAX_RUNS.
// The result strobe follows the last busy cycle; command 3 produces nothing.
// Reset clears the sequencer; counts past the fill mark read as zero. The result side cannot stall.
module binary_row_run_table #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RUNS   = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic       pixel,
  input  logic [7:0] column,
  input  logic [7:0] row,
  input  logic [6:0] run_index,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output logic       done,
  output logic       status,
  output logic [7:0] out_row,
  output logic [6:0] out_index,
  output logic [7:0] run_start,
  output logic [8:0] run_length,
  output logic       is_data
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int LEN_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int ST_DEPTH = MAX_HEIGHT * MAX_RUNS;
  localparam int ADDR_W   = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int ENT_W    = COL_W + LEN_W;
  localparam int CMP_A    = (LEN_W + 1 > 10) ? LEN_W + 1 : 10;
  localparam int CMP_W    = (HGT_W + 1 > CMP_A) ? HGT_W + 1 : CMP_A;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_QCNT,
    S_QSCAN,
    S_RDCNT,
    S_RDDAT
  } state_t;

  state_t state;

  // Configuration registers
  logic       data_color;
  logic [8:0] image_width;
  logic [8:0] image_height;
  logic [LEN_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  // Load position and open run
  logic [COL_W-1:0] load_column;
  logic [ROW_W-1:0] load_row;
  logic [COL_W-1:0] open_start;
  logic [LEN_W-1:0] open_len;
  logic [HGT_W-1:0] fill;

  // Latched command fields
  logic       q_pixel;
  logic [7:0] q_column;
  logic [7:0] q_row;
  logic [6:0] q_index;
  logic       q_ok;
  logic [CNT_W-1:0] q_cnt;
  logic [CNT_W-1:0] scan_i;
  logic [ROW_W-1:0] cnt_row;

  // Memory ports
  logic             cnt_wr_en;
  logic [ROW_W-1:0] cnt_rd_addr;
  logic             cnt_rd_en;
  logic [CNT_W-1:0] cnt_rdata;
  logic [CNT_W-1:0] cnt_val;
  logic             st_wr_en;
  logic [ADDR_W-1:0] st_wr_addr;
  logic [ENT_W-1:0] st_wr_data;
  logic             st_rd_en;
  logic [ADDR_W-1:0] st_rd_addr;
  logic [ENT_W-1:0] st_rdata;
  logic [COL_W-1:0] rd_s;
  logic [LEN_W-1:0] rd_l;

  // Load update terms
  logic             accept;
  logic [ROW_W-1:0] row_eff;
  logic             col_zero;
  logic [CNT_W-1:0] ld_n;
  logic [CNT_W-1:0] ld_n_new;
  logic [LEN_W-1:0] ld_len0;
  logic             is_dc;
  logic             ld_last;
  logic [COL_W-1:0] run_s;
  logic [LEN_W-1:0] run_l;
  logic             ld_close;
  logic             ld_room;
  logic [CMP_W-1:0] row_inc;
  logic [ROW_W-1:0] row_wrap;
  logic [ADDR_W-1:0] q_base;
  logic             hit;
  logic             scan_end;
  logic             rd_ok;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Clamp the configured image size into the supported range
  always_comb begin
    if (image_width == 9'd0) begin
      eff_w = LEN_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = LEN_W'(MAX_WIDTH);
    end else begin
      eff_w = LEN_W'(image_width);
    end
    if (image_height == 9'd0) begin
      eff_h = HGT_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(image_height);
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_color   <= 1'b1;
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        brrt_pkg::REG_DATA_COLOR:   data_color   <= cfg_data[0];
        brrt_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        brrt_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count memory read: issue at the command transfer
  assign row_eff     = (CMP_W'(load_row) >= CMP_W'(eff_h)) ? '0 : load_row;
  assign cnt_rd_en   = accept;
  assign cnt_rd_addr = (command == brrt_pkg::CMD_LOAD) ? row_eff : ROW_W'(row);
  assign cnt_val     = (CMP_W'(cnt_row) < CMP_W'(fill)) ? cnt_rdata : '0;

  // Load update: extend, close or keep the open run
  always_comb begin
    col_zero = (load_column == '0);
    ld_n     = col_zero ? '0 : cnt_val;
    ld_len0  = col_zero ? '0 : open_len;
    is_dc    = (q_pixel == data_color);
    ld_last  = (CMP_W'(load_column) + CMP_W'(1)) >= CMP_W'(eff_w);
    if (is_dc) begin
      run_s    = (ld_len0 == '0) ? load_column : open_start;
      run_l    = ld_len0 + LEN_W'(1);
      ld_close = ld_last;
    end else begin
      run_s    = open_start;
      run_l    = ld_len0;
      ld_close = (ld_len0 != '0);
    end
    ld_room  = (int'(ld_n) < MAX_RUNS);
    ld_n_new = (ld_close && ld_room) ? ld_n + CNT_W'(1) : ld_n;
    row_inc  = CMP_W'(load_row) + CMP_W'(1);
    row_wrap = (row_inc >= CMP_W'(eff_h)) ? '0 : ROW_W'(row_inc);
  end

  // Memory writes of a load
  assign cnt_wr_en  = (state == S_LOAD);
  assign st_wr_en   = (state == S_LOAD) && ld_close && ld_room;
  assign st_wr_addr = ADDR_W'(load_row) * ADDR_W'(MAX_RUNS) + ADDR_W'(ld_n);
  assign st_wr_data = {run_s, run_l};

  // Run memory read address for queries and run reads
  assign q_base = ADDR_W'(ROW_W'(q_row)) * ADDR_W'(MAX_RUNS);
  always_comb begin
    st_rd_en   = 1'b0;
    st_rd_addr = q_base;
    case (state)
      S_QCNT: begin
        st_rd_en = 1'b1;
      end
      S_QSCAN: begin
        st_rd_en   = 1'b1;
        st_rd_addr = q_base + ADDR_W'(scan_i + CNT_W'(1));
      end
      S_RDCNT: begin
        st_rd_en   = 1'b1;
        st_rd_addr = q_base + ADDR_W'(q_index);
      end
      default: ;
    endcase
  end

  // Compare the fetched run against the query column
  assign rd_s     = st_rdata[ENT_W-1:LEN_W];
  assign rd_l     = st_rdata[LEN_W-1:0];
  assign hit      = (CMP_W'(q_column) >= CMP_W'(rd_s)) &&
                    (CMP_W'(q_column) < CMP_W'(rd_s) + CMP_W'(rd_l));
  assign scan_end = (scan_i + CNT_W'(1)) >= q_cnt;
  assign rd_ok    = q_ok && (CMP_W'(q_index) < CMP_W'(cnt_val));

  // Sequencer with load position and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      load_column <= '0;
      load_row    <= '0;
      open_start  <= '0;
      open_len    <= '0;
      fill        <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_pixel  <= pixel;
            q_column <= column;
            q_row    <= row;
            q_index  <= run_index;
            cnt_row  <= cnt_rd_addr;
            case (brrt_pkg::cmd_e_t'(command))
              brrt_pkg::CMD_LOAD: begin
                load_row <= row_eff;
                state    <= S_LOAD;
              end
              brrt_pkg::CMD_QUERY: begin
                q_ok  <= (CMP_W'(row) < CMP_W'(eff_h)) && (CMP_W'(column) < CMP_W'(eff_w));
                state <= S_QCNT;
              end
              brrt_pkg::CMD_READ: begin
                q_ok  <= (CMP_W'(row) < CMP_W'(eff_h));
                state <= S_RDCNT;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          if (CMP_W'(load_row) >= CMP_W'(fill)) begin
            fill <= HGT_W'(row_inc);
          end
          if (ld_close) begin
            done       <= 1'b1;
            status     <= !ld_room;
            out_row    <= 8'(load_row);
            out_index  <= ld_room ? 7'(ld_n) : 7'd0;
            run_start  <= 8'(run_s);
            run_length <= 9'(run_l);
            is_data    <= 1'b0;
          end
          if (is_dc && !ld_last) begin
            open_start <= run_s;
            open_len   <= run_l;
          end else begin
            open_start <= '0;
            open_len   <= '0;
          end
          if (ld_last) begin
            load_column <= '0;
            load_row    <= row_wrap;
          end else begin
            load_column <= load_column + COL_W'(1);
          end
          state <= S_IDLE;
        end
        S_QCNT: begin
          q_cnt  <= cnt_val;
          scan_i <= '0;
          if (!q_ok || cnt_val == '0) begin
            done       <= 1'b1;
            status     <= 1'b1;
            out_row    <= q_row;
            out_index  <= 7'd0;
            run_start  <= 8'd0;
            run_length <= 9'd0;
            is_data    <= 1'b0;
            state      <= S_IDLE;
          end else begin
            state <= S_QSCAN;
          end
        end
        S_QSCAN: begin
          if (hit || scan_end) begin
            done       <= 1'b1;
            status     <= !hit;
            out_row    <= q_row;
            out_index  <= hit ? 7'(scan_i) : 7'd0;
            run_start  <= hit ? 8'(rd_s) : 8'd0;
            run_length <= hit ? 9'(rd_l) : 9'd0;
            is_data    <= hit;
            state      <= S_IDLE;
          end else begin
            scan_i <= scan_i + CNT_W'(1);
          end
        end
        S_RDCNT: begin
          if (rd_ok) begin
            state <= S_RDDAT;
          end else begin
            done       <= 1'b1;
            status     <= 1'b1;
            out_row    <= q_row;
            out_index  <= q_index;
            run_start  <= 8'd0;
            run_length <= 9'd0;
            is_data    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_RDDAT: begin
          done       <= 1'b1;
          status     <= 1'b0;
          out_row    <= q_row;
          out_index  <= q_index;
          run_start  <= 8'(rd_s);
          run_length <= 9'(rd_l);
          is_data    <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Run count per row
  brrt_ram #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (CNT_W)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (load_row),
    .wr_data (ld_n_new),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rdata)
  );

  // Stored runs, MAX_RUNS entries per row
  brrt_ram #(
    .DEPTH (ST_DEPTH),
    .WIDTH (ENT_W)
  ) u_run_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rdata)
  );

endmodule

// ===== rtl/core/brrt_check.sv =====
// Port-level checker of the binary row run table and its bind.
`include "binary_row_run_table_macros.svh"

module brrt_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       done,
  input logic       status,
  input logic       is_data
);

  // A result always closes a busy interval
  `BRRT_ASSERT_IMP(a_done_after_busy, clk, rst, done, $past(busy), "result without work")

  // Results never come in two adjacent cycles
  `BRRT_ASSERT_NXT(a_done_single, clk, rst, done, !done, "back-to-back result strobes")

  // A query always takes the sequencer through the count read
  `BRRT_ASSERT_NXT(a_query_busy, clk, rst,
    start && !busy && (command == brrt_pkg::CMD_QUERY), busy, "query not started")

  // A transfer of command 3 produces no result
  `BRRT_ASSERT_NXT(a_nop_silent, clk, rst,
    start && !busy && (command == brrt_pkg::CMD_NOP), !done, "result for idle command")

  // A pixel found in a run reports success
  `BRRT_ASSERT_IMP(a_data_found, clk, rst, done && is_data, !status, "data flag on a miss")

endmodule

bind binary_row_run_table brrt_check u_brrt_check (.*);
